// ===== src/mmst_pkg.sv =====
// ----------------------------------------------------------------------------
// mmst_pkg: shared types and constants
// Field widths, the job record passed through the queue and the result layout.
// ----------------------------------------------------------------------------
package mmst_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 27;
  localparam int GAMMA_BITS  = 12;
  localparam int STATUS_BITS = 2;

  localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
  localparam int SQ_BITS   = 2 * SAMPLE_BITS + COUNT_BITS;
  localparam int MEAN_BITS = SAMPLE_BITS + 8;
  localparam int THR_BITS  = SAMPLE_BITS + 13;

  // fixed point: mean gets 8 fraction bits, variance 16 (so its root has 8)
  localparam int MEAN_SHIFT = 8;
  localparam int VAR_SHIFT  = 16;

  // N*Q and S*S both fit this width
  localparam int PROD_BITS = SQ_BITS + COUNT_BITS;
  localparam int DIV_BITS  = PROD_BITS + VAR_SHIFT;
  localparam int DVS_BITS  = 2 * COUNT_BITS;
  localparam int REM_BITS  = DVS_BITS + 1;
  localparam int ROOT_BITS = MEAN_BITS;
  localparam int RAD_BITS  = 2 * ROOT_BITS;
  localparam int SQR_BITS  = ROOT_BITS + 2;
  localparam int STEP_BITS = $clog2(DIV_BITS + 1);

  // queue between front and back (depth must be a power of two)
  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_LVL_BITS = $clog2(FIFO_DEPTH + 1);

  localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_BITS       = 2 * MEAN_BITS + THR_BITS + COUNT_BITS + STATUS_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_EMPTY  = 2'd1,
    STATUS_SINGLE = 2'd2
  } status_t;

  // one finished volume: count, sum, sum of squares
  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [SUM_BITS-1:0]   sum;
    logic [SQ_BITS-1:0]    sq;
  } job_t;

  typedef struct packed {
    logic                     empty;
    logic [FIFO_LVL_BITS-1:0] level;
  } fifo_stat_t;

  // last member lands in the lowest bits
  typedef struct packed {
    status_t               status;
    logic [COUNT_BITS-1:0] count;
    logic [THR_BITS-1:0]   thr;
    logic [MEAN_BITS-1:0]  sigma;
    logic [MEAN_BITS-1:0]  mean;
  } res_t;

endpackage

// ===== src/mmst_front.sv =====
// ----------------------------------------------------------------------------
// mmst_front: voxel accumulator
// Two-stage front: count/sum and squaring, then sum of squares and queue push.
// ----------------------------------------------------------------------------
module mmst_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [mmst_pkg::IN_TDATA_BITS-1:0]   s_tdata,
  input  logic                                 s_tlast,
  input  mmst_pkg::fifo_stat_t                 fifo_stat,
  output logic                                 push,
  output mmst_pkg::job_t                       push_data
);

  localparam int SB = mmst_pkg::SAMPLE_BITS;
  localparam int CB = mmst_pkg::COUNT_BITS;
  localparam int UB = mmst_pkg::SUM_BITS;
  localparam int QB = mmst_pkg::SQ_BITS;
  localparam int LB = mmst_pkg::FIFO_LVL_BITS;

  logic          accept;
  logic [SB-1:0] voxel;
  logic          counted;
  logic [CB-1:0] count, count_next;
  logic [UB-1:0] sum, sum_next;
  logic [2*SB-1:0] sq_pipe;
  logic          sq_add;
  logic          b_last;
  logic [CB-1:0] snap_count;
  logic [UB-1:0] snap_sum;
  logic [QB-1:0] square_sum, sq_total;

  // leave room for the push that stage B may still owe
  assign s_tready = ({1'b0, fifo_stat.level} + {{LB{1'b0}}, b_last})
                    < (LB+1)'(mmst_pkg::FIFO_DEPTH);
  assign accept   = s_tvalid && s_tready;
  assign voxel    = s_tdata[SB-1:0];
  assign counted  = accept && (voxel != '0) && (count != '1);

  assign count_next = count + {{(CB-1){1'b0}}, counted};
  assign sum_next   = sum + (counted ? {{(UB-SB){1'b0}}, voxel} : '0);
  assign sq_total   = square_sum + (sq_add ? {{(QB-2*SB){1'b0}}, sq_pipe} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      sum        <= '0;
      square_sum <= '0;
      sq_add     <= 1'b0;
      b_last     <= 1'b0;
    end else begin
      sq_add <= counted;
      b_last <= accept && s_tlast;
      if (accept && s_tlast) begin
        count <= '0;
        sum   <= '0;
      end else begin
        count <= count_next;
        sum   <= sum_next;
      end
      square_sum <= b_last ? '0 : sq_total;
    end
  end

  always_ff @(posedge clk) begin
    sq_pipe <= {{SB{1'b0}}, voxel} * {{SB{1'b0}}, voxel};
    if (accept && s_tlast) begin
      snap_count <= count_next;
      snap_sum   <= sum_next;
    end
  end

  assign push            = b_last;
  assign push_data.count = snap_count;
  assign push_data.sum   = snap_sum;
  assign push_data.sq    = sq_total;

endmodule

// ===== src/mmst_fifo.sv =====
// ----------------------------------------------------------------------------
// mmst_fifo: job queue
// Short register queue that decouples the accumulator from the solver.
// ----------------------------------------------------------------------------
module mmst_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mmst_pkg::job_t       push_data,
  input  logic                 pop,
  output mmst_pkg::job_t       pop_data,
  output mmst_pkg::fifo_stat_t fifo_stat
);

  localparam int PB = mmst_pkg::FIFO_PTR_BITS;
  localparam int LB = mmst_pkg::FIFO_LVL_BITS;

  mmst_pkg::job_t mem [mmst_pkg::FIFO_DEPTH];
  logic [PB-1:0] wr_ptr, rd_ptr;
  logic [LB-1:0] level;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PB'(1);
      if (pop)  rd_ptr <= rd_ptr + PB'(1);
      level <= level + {{(LB-1){1'b0}}, push} - {{(LB-1){1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  assign pop_data        = mem[rd_ptr];
  assign fifo_stat.level = level;
  assign fifo_stat.empty = (level == '0);

endmodule

// ===== src/mmst_back.sv =====
// ----------------------------------------------------------------------------
// mmst_back: statistics solver
// Sequencer around a shift-add multiplier, a restoring divider and a
// digit-by-digit square root; holds the result until it is taken.
// ----------------------------------------------------------------------------
module mmst_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  mmst_pkg::fifo_stat_t                  fifo_stat,
  output logic                                  pop,
  input  mmst_pkg::job_t                        pop_data,
  input  logic [mmst_pkg::GAMMA_BITS-1:0]       gamma,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [mmst_pkg::OUT_TDATA_BITS-1:0]   m_tdata
);

  localparam int CB  = mmst_pkg::COUNT_BITS;
  localparam int UB  = mmst_pkg::SUM_BITS;
  localparam int QB  = mmst_pkg::SQ_BITS;
  localparam int PB  = mmst_pkg::PROD_BITS;
  localparam int DB  = mmst_pkg::DIV_BITS;
  localparam int VB  = mmst_pkg::DVS_BITS;
  localparam int RB  = mmst_pkg::REM_BITS;
  localparam int TB  = mmst_pkg::ROOT_BITS;
  localparam int AB  = mmst_pkg::RAD_BITS;
  localparam int SRB = mmst_pkg::SQR_BITS;
  localparam int SB  = mmst_pkg::STEP_BITS;
  localparam int MB  = mmst_pkg::MEAN_BITS;
  localparam int HB  = mmst_pkg::THR_BITS;
  localparam int GB  = mmst_pkg::GAMMA_BITS;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b00_0000_0001,
    ST_DIV_MEAN = 10'b00_0000_0010,
    ST_MUL_NQ   = 10'b00_0000_0100,
    ST_MUL_SS   = 10'b00_0000_1000,
    ST_DIFF     = 10'b00_0001_0000,
    ST_MUL_NN   = 10'b00_0010_0000,
    ST_DIV_VAR  = 10'b00_0100_0000,
    ST_SQRT     = 10'b00_1000_0000,
    ST_THR      = 10'b01_0000_0000,
    ST_OUT      = 10'b10_0000_0000
  } state_t;

  state_t state;
  logic [SB-1:0] step;
  logic          step_last;

  logic [CB-1:0] n;
  logic [UB-1:0] s;
  logic [QB-1:0] q;

  // multiplier
  logic [QB-1:0] mul_a;
  logic [UB-1:0] mul_b;
  logic [PB-1:0] acc, mul_sum, nq;

  // divider: quotient bits shift in at the bottom of dvd
  logic [DB-1:0] dvd, dvd_new;
  logic [VB-1:0] dvs;
  logic [RB-1:0] rem, rem_sh, rem_new;
  logic          div_ge;

  // square root
  logic [AB-1:0]    rad;
  logic [SRB-1:0]   sq_rem, sr_new;
  logic [SRB+1:0]   sr_sh, sr_trial;
  logic [TB-1:0]    root, root_new;
  logic             sr_ge;

  logic [MB-1:0] mean, sigma;
  mmst_pkg::status_t status;
  mmst_pkg::res_t    res;

  logic [GB+MB-1:0] gprod;
  logic [HB:0]      thr_full;
  logic [HB-1:0]    thr_sat;

  assign step_last = (step == SB'(1));

  assign mul_sum = {acc[PB-2:0], 1'b0} + (mul_b[UB-1] ? {{(PB-QB){1'b0}}, mul_a} : '0);

  assign rem_sh  = {rem[RB-2:0], dvd[DB-1]};
  assign div_ge  = (rem_sh >= {1'b0, dvs});
  assign rem_new = div_ge ? (rem_sh - {1'b0, dvs}) : rem_sh;
  assign dvd_new = {dvd[DB-2:0], div_ge};

  assign sr_sh    = {sq_rem, rad[AB-1 -: 2]};
  assign sr_trial = {{(SRB-TB){1'b0}}, root, 2'b01};
  assign sr_ge    = (sr_sh >= sr_trial);
  assign sr_new   = sr_ge ? SRB'(sr_sh - sr_trial) : SRB'(sr_sh);
  assign root_new = {root[TB-2:0], sr_ge};

  assign gprod    = {{MB{1'b0}}, gamma} * {{GB{1'b0}}, sigma};
  assign thr_full = (HB+1)'(mean) + (HB+1)'(gprod >> mmst_pkg::MEAN_SHIFT);
  assign thr_sat  = thr_full[HB] ? '1 : thr_full[HB-1:0];

  assign pop = (state == ST_IDLE) && !fifo_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!fifo_stat.empty) begin
            if (pop_data.count == '0) state <= ST_THR;
            else                      state <= ST_DIV_MEAN;
          end
        end
        ST_DIV_MEAN: begin
          if (step_last) state <= (n == CB'(1)) ? ST_THR : ST_MUL_NQ;
        end
        ST_MUL_NQ:  if (step_last) state <= ST_MUL_SS;
        ST_MUL_SS:  if (step_last) state <= ST_DIFF;
        ST_DIFF:    state <= ST_MUL_NN;
        ST_MUL_NN:  if (step_last) state <= ST_DIV_VAR;
        ST_DIV_VAR: if (step_last) state <= ST_SQRT;
        ST_SQRT:    if (step_last) state <= ST_THR;
        ST_THR:     state <= ST_OUT;
        ST_OUT:     if (m_tready) state <= ST_IDLE;
        default:    state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        n      <= pop_data.count;
        s      <= pop_data.sum;
        q      <= pop_data.sq;
        mean   <= '0;
        sigma  <= '0;
        status <= mmst_pkg::STATUS_EMPTY;
        dvd    <= DB'({pop_data.sum, {mmst_pkg::MEAN_SHIFT{1'b0}}});
        dvs    <= VB'(pop_data.count);
        rem    <= '0;
        step   <= SB'(DB);
      end
      ST_DIV_MEAN: begin
        dvd <= dvd_new;
        rem <= rem_new;
        if (step_last) begin
          mean   <= dvd_new[MB-1:0];
          status <= (n == CB'(1)) ? mmst_pkg::STATUS_SINGLE : mmst_pkg::STATUS_OK;
          mul_a  <= q;
          mul_b  <= UB'(n);
          acc    <= '0;
          step   <= SB'(UB);
        end else begin
          step <= step - SB'(1);
        end
      end
      ST_MUL_NQ: begin
        if (step_last) begin
          nq    <= mul_sum;
          mul_a <= QB'(s);
          mul_b <= s;
          acc   <= '0;
          step  <= SB'(UB);
        end else begin
          acc   <= mul_sum;
          mul_b <= {mul_b[UB-2:0], 1'b0};
          step  <= step - SB'(1);
        end
      end
      ST_MUL_SS: begin
        acc   <= mul_sum;
        mul_b <= {mul_b[UB-2:0], 1'b0};
        step  <= step - SB'(1);
      end
      ST_DIFF: begin
        // N*Q - S*S, clamped at zero
        nq    <= (nq > acc) ? (nq - acc) : '0;
        mul_a <= QB'(n);
        mul_b <= UB'(n - CB'(1));
        acc   <= '0;
        step  <= SB'(UB);
      end
      ST_MUL_NN: begin
        if (step_last) begin
          dvs  <= mul_sum[VB-1:0];
          dvd  <= {nq, {mmst_pkg::VAR_SHIFT{1'b0}}};
          rem  <= '0;
          step <= SB'(DB);
        end else begin
          acc   <= mul_sum;
          mul_b <= {mul_b[UB-2:0], 1'b0};
          step  <= step - SB'(1);
        end
      end
      ST_DIV_VAR: begin
        dvd <= dvd_new;
        rem <= rem_new;
        if (step_last) begin
          // scaled variance stays below 2^RAD_BITS
          rad    <= dvd_new[AB-1:0];
          sq_rem <= '0;
          root   <= '0;
          step   <= SB'(TB);
        end else begin
          step <= step - SB'(1);
        end
      end
      ST_SQRT: begin
        rad    <= {rad[AB-3:0], 2'b00};
        sq_rem <= sr_new;
        root   <= root_new;
        step   <= step - SB'(1);
        if (step_last) sigma <= root_new;
      end
      ST_THR: begin
        res.mean   <= mean;
        res.sigma  <= sigma;
        res.thr    <= thr_sat;
        res.count  <= n;
        res.status <= status;
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {{(mmst_pkg::OUT_TDATA_BITS - mmst_pkg::OUT_BITS){1'b0}}, res};

endmodule

// ===== src/masked_mean_stddev_threshold.sv =====
// Solver: a volume with two or more nonzero voxels takes every step; with one it
//   skips the variance and root, and with none it goes straight to the threshold.
// Throughput: one voxel per cycle while the queue has room; one job at a time in
//   the bit-serial divider (two passes), multiplier (three passes) and root.
// Reset: synchronous, active high; clears accumulators, queue, solver and gamma.
// ----------------------------------------------------------------------------
// masked_mean_stddev_threshold: masked voxel statistics
// Mean, sample standard deviation and mean + gamma*sigma over nonzero voxels.
// ----------------------------------------------------------------------------
module masked_mean_stddev_threshold (
  input  logic                                 clk,
  input  logic                                 rst,
  // voxel stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [mmst_pkg::IN_TDATA_BITS-1:0]   s_tdata,   // [15:0] voxel
  input  logic                                 s_tlast,   // last_voxel
  // gamma_q8 register write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mmst_pkg::GAMMA_BITS-1:0]      cfg_data,
  // result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [23:0] mean_q8, [47:24] sigma_q8, [76:48] threshold_q8,
  // [103:77] voxel_count, [105:104] status, [111:106] zero
  output logic [mmst_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);

  // Front: accumulates count, sum and sum of squares of nonzero voxels at full
  // rate while the queue has room. Zero voxels are masked out; once the count
  // saturates further voxels are dropped. A transaction with tlast closes the
  // volume and pushes one job into the queue.
  // Back: per job, mean = (S<<8)/N, then (N*Q - S*S)<<16 / (N*(N-1)) and its
  // integer root as sigma, then threshold = mean + (gamma*sigma)>>8,
  // saturated. The result waits in a register while the front keeps going.

  logic [mmst_pkg::GAMMA_BITS-1:0] gamma;

  mmst_pkg::fifo_stat_t fifo_stat;
  mmst_pkg::job_t       push_data, pop_data;
  logic                 push, pop;

  // gamma register; writes are only expected while the block is idle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= '0;
    end else if (cfg_valid && cfg_ready) begin
      gamma <= cfg_data;
    end
  end

  mmst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .fifo_stat (fifo_stat),
    .push      (push),
    .push_data (push_data)
  );

  // two jobs of slack so a new volume can close while the back is busy
  mmst_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .fifo_stat (fifo_stat)
  );

  mmst_back u_back (
    .clk       (clk),
    .rst       (rst),
    .fifo_stat (fifo_stat),
    .pop       (pop),
    .pop_data  (pop_data),
    .gamma     (gamma),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== src/mmst_checker.sv =====
// ----------------------------------------------------------------------------
// mmst_checker: result port checks
// Consistency of the result fields, output hold behavior and no valid after reset.
// ----------------------------------------------------------------------------
module mmst_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [mmst_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

  mmst_pkg::res_t res;
  assign res = mmst_pkg::res_t'(m_tdata[mmst_pkg::OUT_BITS-1:0]);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.status == mmst_pkg::STATUS_EMPTY |->
      res.count == '0 && res.mean == '0 && res.sigma == '0 && res.thr == '0)
    else $error("empty volume with nonzero fields");

  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.status == mmst_pkg::STATUS_SINGLE |->
      res.count == mmst_pkg::COUNT_BITS'(1) && res.sigma == '0 &&
      res.thr == mmst_pkg::THR_BITS'(res.mean))
    else $error("single voxel result inconsistent");

  a_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.status == mmst_pkg::STATUS_OK |->
      res.count > mmst_pkg::COUNT_BITS'(1))
    else $error("ok status with fewer than two voxels");

endmodule

bind masked_mean_stddev_threshold mmst_checker u_mmst_checker (.*);
